@@ rtl/dmmr_pkg.sv @@
// shared types and constants of the dual motor mix and ramp unit
// register codes, reset values and the configuration structs; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dmmr_pkg;

   localparam int LANES = 2;
   localparam int LANE_A = 0;
   localparam int LANE_B = 1;

   localparam int CFG_WIDE_BITS = 16;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PULSE_CENTER = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PULSE_MIN    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PULSE_MAX    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEADBAND     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FULL_ON      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAMP_STEP    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ARCADE       = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REVERSE      = 3'd7;

   localparam logic [CFG_WIDE_BITS-1:0] RESET_CENTER = 16'd1500;
   localparam logic [CFG_WIDE_BITS-1:0] RESET_MIN    = 16'd1000;
   localparam logic [CFG_WIDE_BITS-1:0] RESET_MAX    = 16'd2000;
   localparam logic [7:0] RESET_DEADBAND  = 8'd50;
   localparam logic [7:0] RESET_FULL_ON   = 8'd25;
   localparam logic [7:0] RESET_RAMP_STEP = 8'd2;

   typedef struct packed {
      logic [CFG_WIDE_BITS-1:0] center;
      logic [CFG_WIDE_BITS-1:0] min;
      logic [CFG_WIDE_BITS-1:0] max;
      logic [7:0]               deadband;
      logic [7:0]               margin;
   } clamp_cfg_type;

   typedef struct packed {
      clamp_cfg_type clamp;
      logic [7:0]    ramp_step;
      logic          arcade;
      logic [1:0]    reverse;
   } cfg_type;

endpackage

`default_nettype wire

@@ rtl/dmmr_clamp.sv @@
// pulse clamp with full-on margins and center deadband, combinational
// depends on dmmr_pkg for the clamp configuration struct
`timescale 1ns / 1ps
`default_nettype none

module dmmr_clamp
   import dmmr_pkg::*;
#(
   parameter int VALUE_BITS = 16
) (
   input  logic signed [VALUE_BITS-1:0] value,
   input  clamp_cfg_type                cfg,
   output logic signed [VALUE_BITS-1:0] result
);

   logic signed [VALUE_BITS-1:0] center;
   logic signed [VALUE_BITS-1:0] pmin;
   logic signed [VALUE_BITS-1:0] pmax;
   logic signed [VALUE_BITS-1:0] low_snap;
   logic signed [VALUE_BITS-1:0] high_snap;
   logic signed [VALUE_BITS-1:0] dead_low;
   logic signed [VALUE_BITS-1:0] dead_high;

   assign center    = signed'(VALUE_BITS'(cfg.center));
   assign pmin      = signed'(VALUE_BITS'(cfg.min));
   assign pmax      = signed'(VALUE_BITS'(cfg.max));
   assign low_snap  = pmin + signed'(VALUE_BITS'(cfg.margin));
   assign high_snap = pmax - signed'(VALUE_BITS'(cfg.margin));
   assign dead_low  = center - signed'(VALUE_BITS'(cfg.deadband));
   assign dead_high = center + signed'(VALUE_BITS'(cfg.deadband));

   always_comb begin
      priority if (value < low_snap) begin
         result = pmin;
      end else if (value < dead_low) begin
         result = value;
      end else if (value <= dead_high) begin
         result = center;
      end else if (value <= high_snap) begin
         result = value;
      end else begin
         result = pmax;
      end
   end

endmodule

`default_nettype wire

@@ rtl/dmmr_ramp_lane.sv @@
// one motor lane: speed and direction from the mixed pulse, ramp limited
// holds the previous speed and direction, which are also the lane output
`timescale 1ns / 1ps
`default_nettype none

module dmmr_ramp_lane #(
   parameter int PULSE_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      update,
   input  logic signed [PULSE_BITS+3:0] radio,
   input  logic [PULSE_BITS-1:0]     center,
   input  logic [7:0]                step,
   output logic [PULSE_BITS-1:0]     speed,
   output logic                      dir
);

   localparam int VW = PULSE_BITS + 4;
   localparam int SW = PULSE_BITS + 1;

   logic [PULSE_BITS-1:0] speed_ff;
   logic [PULSE_BITS-1:0] speed_in;
   logic                  dir_ff;
   logic                  dir_in;

   logic signed [VW-1:0] diff;
   logic [VW-1:0]        diff_abs;
   logic [SW-1:0]        spd;
   logic [SW-1:0]        prev;
   logic [SW-1:0]        st;
   logic                 new_dir;
   logic [SW-1:0]        ramped;
   logic                 ramped_dir;

   assign diff     = radio - signed'(VW'(center));
   assign diff_abs = diff[VW-1] ? VW'(-diff) : VW'(diff);
   assign new_dir  = (diff > 0);
   assign spd      = {1'b0, diff_abs[PULSE_BITS-1:0]};
   assign prev     = {1'b0, speed_ff};
   assign st       = SW'(step);

   always_comb begin
      ramped     = spd;
      ramped_dir = new_dir;
      priority if (spd == '0) begin
         ramped = spd;
      end else if (new_dir == dir_ff) begin
         priority if (spd > prev && (spd - prev) > st) begin
            ramped = prev + st;
         end else if (spd < prev && (prev - spd) > st) begin
            ramped = prev - st;
         end else begin
            ramped = spd;
         end
      end else if ((spd + prev) > st) begin
         priority if (prev == st) begin
            ramped = '0;
         end else if (prev > st) begin
            ramped     = prev - st;
            ramped_dir = dir_ff;
         end else begin
            ramped = st - prev;
         end
      end else begin
         ramped = spd;
      end
   end

   assign speed_in = update ? ramped[PULSE_BITS-1:0] : speed_ff;
   assign dir_in   = update ? ramped_dir : dir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= '0;
         dir_ff   <= 1'b0;
      end else begin
         speed_ff <= speed_in;
         dir_ff   <= dir_in;
      end
   end

   assign speed = speed_ff;
   assign dir   = dir_ff;

   // centered input cuts the motor at once
   a_center_cut : assert property (@(posedge clock) disable iff (reset)
      (update && radio == signed'(VW'(center))) |=> (speed_ff == '0 && !dir_ff))
      else $error("centered input did not stop the motor");

   // speed never rises by more than the step
   a_slew : assert property (@(posedge clock) disable iff (reset)
      update |=> ({1'b0, speed_ff} <= {1'b0, $past(speed_ff)} + SW'($past(step))))
      else $error("speed rose faster than the ramp step");

   a_reset_state : assert property (@(posedge clock)
      reset |=> (speed_ff == '0 && !dir_ff))
      else $error("lane state not cleared by reset");

endmodule

`default_nettype wire

@@ rtl/dual_motor_mix_ramp_unit.sv @@
// top level of the dual motor mix and ramp unit: stream ports, registers, pipeline
// depends on dmmr_pkg, dmmr_clamp and dmmr_ramp_lane
`timescale 1ns / 1ps
`default_nettype none

// Takes one update tick per cycle unless stalled and returns one motor command
// per tick. Stage one clamps and optionally mirrors each channel in its own
// lane, stage two optionally mixes throttle and steering and clamps again,
// stage three runs the per-motor ramp limiters, whose speed and direction
// registers feed back into the next tick within that single stage; that loop
// allows one tick per cycle. The pipeline moves as a whole whenever the result
// register is empty or being taken. Configuration writes take effect at once
// and are meant for times with no tick in flight.

module dual_motor_mix_ramp_unit
   import dmmr_pkg::*;
#(
   parameter int PULSE_BITS = 12
) (
   input  logic clock,
   input  logic reset,

   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // pulse_a, pulse_b, zero fill
   input  logic [((2*PULSE_BITS+7)/8)*8-1:0]     req_tdata,
   // fault, lost_a, lost_b
   input  logic [2:0]                            req_tuser,

   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // speed_a, dir_a, speed_b, dir_b, zero fill
   output logic [((2*PULSE_BITS+2+7)/8)*8-1:0]   rsp_tdata,

   input  logic                                  csr_we,
   input  logic [CSR_INDEX_BITS-1:0]             csr_index,
   input  logic [PULSE_BITS-1:0]                 csr_wdata
);

   localparam int VW = PULSE_BITS + 4;
   localparam int RSP_BITS = ((2*PULSE_BITS+2+7)/8)*8;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PULSE_CENTER: cfg_in.clamp.center   = CFG_WIDE_BITS'(csr_wdata);
            CSR_PULSE_MIN:    cfg_in.clamp.min      = CFG_WIDE_BITS'(csr_wdata);
            CSR_PULSE_MAX:    cfg_in.clamp.max      = CFG_WIDE_BITS'(csr_wdata);
            CSR_DEADBAND:     cfg_in.clamp.deadband = csr_wdata[7:0];
            CSR_FULL_ON:      cfg_in.clamp.margin   = csr_wdata[7:0];
            CSR_RAMP_STEP:    cfg_in.ramp_step      = csr_wdata[7:0];
            CSR_ARCADE:       cfg_in.arcade         = csr_wdata[0];
            CSR_REVERSE:      cfg_in.reverse        = csr_wdata[1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clamp.center   <= CFG_WIDE_BITS'(PULSE_BITS'(RESET_CENTER));
         cfg_ff.clamp.min      <= CFG_WIDE_BITS'(PULSE_BITS'(RESET_MIN));
         cfg_ff.clamp.max      <= CFG_WIDE_BITS'(PULSE_BITS'(RESET_MAX));
         cfg_ff.clamp.deadband <= RESET_DEADBAND;
         cfg_ff.clamp.margin   <= RESET_FULL_ON;
         cfg_ff.ramp_step      <= RESET_RAMP_STEP;
         cfg_ff.arcade         <= 1'b0;
         cfg_ff.reverse        <= 2'b00;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   logic signed [VW-1:0] center_v;
   logic signed [VW-1:0] span_v;

   assign center_v = signed'(VW'(cfg_ff.clamp.center));
   assign span_v   = signed'(VW'(cfg_ff.clamp.min)) + signed'(VW'(cfg_ff.clamp.max));

   // pipeline control
   logic advance;
   logic valid1_ff, valid1_in;
   logic valid2_ff, valid2_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign advance      = !rsp_valid_ff || rsp_tready;
   assign req_tready   = advance;
   assign valid1_in    = advance ? req_tvalid : valid1_ff;
   assign valid2_in    = advance ? valid1_ff : valid2_ff;
   assign rsp_valid_in = advance ? valid2_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff    <= 1'b0;
         valid2_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid1_ff    <= valid1_in;
         valid2_ff    <= valid2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage one: per-lane clamp and mirror
   logic [PULSE_BITS-1:0] pulse   [LANES];
   logic signed [VW-1:0]  first_in  [LANES];
   logic signed [VW-1:0]  first_out [LANES];
   logic signed [VW-1:0]  mirror  [LANES];
   logic signed [VW-1:0]  lane1_ff [LANES];
   logic signed [VW-1:0]  lane1_in [LANES];
   logic                  hold1_ff, hold1_in;
   logic                  hold;

   assign pulse[LANE_A] = req_tdata[PULSE_BITS-1:0];
   assign pulse[LANE_B] = req_tdata[2*PULSE_BITS-1:PULSE_BITS];
   assign hold = (|req_tuser) || (pulse[LANE_A] == '0) || (pulse[LANE_B] == '0);
   assign hold1_in = advance ? hold : hold1_ff;

   for (genvar l = 0; l < LANES; l++) begin : g_front
      assign first_in[l] = signed'(VW'(pulse[l]));
      dmmr_clamp #(.VALUE_BITS(VW)) u_clamp (
         .value  (first_in[l]),
         .cfg    (cfg_ff.clamp),
         .result (first_out[l])
      );
      assign mirror[l]   = cfg_ff.reverse[l] ? (span_v - first_out[l]) : first_out[l];
      assign lane1_in[l] = advance ? mirror[l] : lane1_ff[l];
   end

   always_ff @(posedge clock) begin
      hold1_ff <= hold1_in;
      lane1_ff <= lane1_in;
   end

   // stage two: optional arcade mix of the lanes, clamp again, center for held ticks
   logic signed [VW-1:0] steer;
   logic signed [VW-1:0] mixed   [LANES];
   logic signed [VW-1:0] second  [LANES];
   logic signed [VW-1:0] lane2_ff [LANES];
   logic signed [VW-1:0] lane2_in [LANES];

   assign steer = lane1_ff[LANE_B] - center_v;
   assign mixed[LANE_A] = cfg_ff.arcade ? (lane1_ff[LANE_A] + steer) : lane1_ff[LANE_A];
   assign mixed[LANE_B] = cfg_ff.arcade ? (lane1_ff[LANE_A] - steer) : lane1_ff[LANE_B];

   for (genvar l = 0; l < LANES; l++) begin : g_mix
      dmmr_clamp #(.VALUE_BITS(VW)) u_clamp (
         .value  (mixed[l]),
         .cfg    (cfg_ff.clamp),
         .result (second[l])
      );
      assign lane2_in[l] = advance ? (hold1_ff ? center_v : second[l]) : lane2_ff[l];
   end

   always_ff @(posedge clock) begin
      lane2_ff <= lane2_in;
   end

   // stage three: ramp limiters, their state is the result
   logic                  ramp_update;
   logic [PULSE_BITS-1:0] speed [LANES];
   logic                  dir   [LANES];

   assign ramp_update = advance && valid2_ff;

   for (genvar l = 0; l < LANES; l++) begin : g_ramp
      dmmr_ramp_lane #(.PULSE_BITS(PULSE_BITS)) u_ramp (
         .clock  (clock),
         .reset  (reset),
         .update (ramp_update),
         .radio  (lane2_ff[l]),
         .center (cfg_ff.clamp.center[PULSE_BITS-1:0]),
         .step   (cfg_ff.ramp_step),
         .speed  (speed[l]),
         .dir    (dir[l])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'({dir[LANE_B], speed[LANE_B], dir[LANE_A], speed[LANE_A]});

   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      (advance && valid2_ff) |=> rsp_tvalid)
      else $error("stage two item did not reach the result register");

   a_bubble_follows : assert property (@(posedge clock) disable iff (reset)
      (advance && !valid2_ff) |=> !rsp_tvalid)
      else $error("result appeared without an item behind it");

   a_frozen : assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(valid1_ff) && $stable(valid2_ff)))
      else $error("pipeline moved while the result was stalled");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// testbench for dual_motor_mix_ramp_unit: directed and random update ticks over many
// register setups, results checked by a scoreboard class that predicts each motor command
// depends on dmmr_pkg and the unit rtl
`timescale 1ns / 1ps

module tb;
   import dmmr_pkg::*;

   typedef struct packed {
      logic [11:0] speed_a;
      logic        dir_a;
      logic [11:0] speed_b;
      logic        dir_b;
   } motor_cmd_type;

   class drive_cmd_scoreboard;
      int center, pmin, pmax, dband, margin, step, arcade, rev_mask;
      int prev_speed [2];
      int prev_dir [2];
      motor_cmd_type pending_cmds [$];
      int failures;
      int checked;

      function new();
         center = int'(RESET_CENTER);
         pmin = int'(RESET_MIN);
         pmax = int'(RESET_MAX);
         dband = int'(RESET_DEADBAND);
         margin = int'(RESET_FULL_ON);
         step = int'(RESET_RAMP_STEP);
         arcade = 0;
         rev_mask = 0;
         prev_speed = '{0, 0};
         prev_dir = '{0, 0};
         failures = 0;
         checked = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [11:0] val);
         case (idx)
            CSR_PULSE_CENTER: center = int'(val);
            CSR_PULSE_MIN:    pmin = int'(val);
            CSR_PULSE_MAX:    pmax = int'(val);
            CSR_DEADBAND:     dband = int'(val[7:0]);
            CSR_FULL_ON:      margin = int'(val[7:0]);
            CSR_RAMP_STEP:    step = int'(val[7:0]);
            CSR_ARCADE:       arcade = int'(val[0]);
            CSR_REVERSE:      rev_mask = int'(val[1:0]);
         endcase
      endfunction

      function int clamp_width(int v);
         if (v < pmin + margin) return pmin;
         if (v < center - dband) return v;
         if (v <= center + dband) return center;
         if (v <= pmax - margin) return v;
         return pmax;
      endfunction

      function void slew_limit(int lane, int pw, output logic [11:0] spd_o,
                               output logic dir_o);
         int spd;
         int dirn;
         int prev;
         prev = prev_speed[lane];
         if (pw > center) begin
            spd = pw - center;
            dirn = 1;
         end else if (pw < center) begin
            spd = center - pw;
            dirn = 0;
         end else begin
            spd = 0;
            dirn = 0;
         end
         spd = spd & 'hFFF;
         if (spd != 0) begin
            if (dirn == prev_dir[lane]) begin
               if (spd > prev && spd - prev > step) spd = prev + step;
               else if (spd < prev && prev - spd > step) spd = prev - step;
            end else if (spd + prev > step) begin
               // reversal: decelerate in the old direction first
               if (prev == step) begin
                  spd = 0;
               end else if (prev > step) begin
                  spd = prev - step;
                  dirn = prev_dir[lane];
               end else begin
                  spd = step - prev;
               end
            end
         end
         spd = spd & 'hFFF;
         prev_speed[lane] = spd;
         prev_dir[lane] = dirn;
         spd_o = spd[11:0];
         dir_o = dirn[0];
      endfunction

      function void note_tick(logic [23:0] data, logic [2:0] user);
         int pa, pb, da, dbv, span, steer;
         motor_cmd_type cmd;
         pa = int'(data[11:0]);
         pb = int'(data[23:12]);
         da = center;
         dbv = center;
         if (user == 3'b000 && pa != 0 && pb != 0) begin
            span = pmin + pmax;
            da = clamp_width(pa);
            dbv = clamp_width(pb);
            if ((rev_mask & 1) != 0) da = span - da;
            if ((rev_mask & 2) != 0) dbv = span - dbv;
            if (arcade != 0) begin
               steer = dbv - center;
               dbv = da - steer;
               da = da + steer;
            end
            da = clamp_width(da);
            dbv = clamp_width(dbv);
         end
         slew_limit(0, da, cmd.speed_a, cmd.dir_a);
         slew_limit(1, dbv, cmd.speed_b, cmd.dir_b);
         pending_cmds.push_back(cmd);
      endfunction

      function void check_cmd(logic [31:0] data);
         motor_cmd_type want;
         motor_cmd_type got;
         got.speed_a = data[11:0];
         got.dir_a = data[12];
         got.speed_b = data[24:13];
         got.dir_b = data[25];
         if (pending_cmds.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected command: speed_a %0d dir_a %0d speed_b %0d dir_b %0d",
                        got.speed_a, got.dir_a, got.speed_b, got.dir_b);
            return;
         end
         want = pending_cmds.pop_front();
         checked++;
         if (got.speed_a !== want.speed_a || got.dir_a !== want.dir_a ||
             got.speed_b !== want.speed_b || got.dir_b !== want.dir_b) begin
            failures++;
            if (failures <= 10)
               $display(
                  "command %0d mismatch: expected a %0d/%0d b %0d/%0d, got a %0d/%0d b %0d/%0d",
                  checked, want.speed_a, want.dir_a, want.speed_b, want.dir_b,
                  got.speed_a, got.dir_a, got.speed_b, got.dir_b);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [11:0] csr_wdata;

   drive_cmd_scoreboard cmd_board = new();
   int tx_gap_pct;
   int rx_stall_pct;
   int hold_off;
   int ticks_sent;
   int setups_run;

   dual_motor_mix_ramp_unit #(.PULSE_BITS(12)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // transfer monitor for both channels
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         cmd_board.note_tick(req_tdata, req_tuser);
         ticks_sent++;
      end
      if (!reset && rsp_tvalid && rsp_tready) cmd_board.check_cmd(rsp_tdata);
   end

   // result sink with random stalls and long hold-offs
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
            hold_off--;
         end else begin
            rsp_tready <= ($urandom_range(1, 100) > rx_stall_pct);
         end
      end
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   task automatic set_traffic(input int mode);
      case (mode)
         0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
         1: begin tx_gap_pct = 65; rx_stall_pct = 0;  end
         2: begin tx_gap_pct = 0;  rx_stall_pct = 65; end
         default: begin tx_gap_pct = 17; rx_stall_pct = 17; end
      endcase
   endtask

   task automatic send_tick(input logic [11:0] pa, input logic [11:0] pb,
                            input logic [2:0] flags);
      if ($urandom_range(1, 100) <= tx_gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(1, 100) <= tx_gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {pb, pa};
      req_tuser <= flags;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_cmds();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (cmd_board.pending_cmds.size() != 0) @(posedge clock);
   endtask

   task automatic configure(input logic [11:0] c, input logic [11:0] lo,
                            input logic [11:0] hi, input logic [11:0] db,
                            input logic [11:0] mg, input logic [11:0] st,
                            input logic [11:0] ar, input logic [11:0] rv);
      logic [CSR_INDEX_BITS-1:0] idx [8];
      logic [11:0] val [8];
      idx = '{CSR_PULSE_CENTER, CSR_PULSE_MIN, CSR_PULSE_MAX, CSR_DEADBAND,
              CSR_FULL_ON, CSR_RAMP_STEP, CSR_ARCADE, CSR_REVERSE};
      val = '{c, lo, hi, db, mg, st, ar, rv};
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         cmd_board.write_reg(idx[i], val[i]);
      end
      csr_we <= 1'b0;
      setups_run++;
   endtask

   // stick positions held for a few ticks so the ramp can follow, with jitter
   task automatic run_random(input int count, input int phase);
      int run_left, r, lo, hi, c, jit;
      logic [11:0] pa, pb;
      logic [2:0] flags;
      run_left = 0;
      for (int i = 0; i < count; i++) begin
         set_traffic((phase + i / 25) % 4);
         if (run_left == 0) begin
            run_left = $urandom_range(1, 12);
            c = cmd_board.center;
            lo = (c > 600) ? c - 600 : 1;
            hi = (c < 3495) ? c + 600 : 4095;
            r = $urandom_range(0, 99);
            if (r < 60) begin
               pa = 12'($urandom_range(lo, hi));
               pb = 12'($urandom_range(lo, hi));
            end else if (r < 85) begin
               pa = 12'($urandom_range(1, 4095));
               pb = 12'($urandom_range(1, 4095));
            end else if (r < 90) begin
               pa = $urandom_range(0, 1) ? 12'd4095 : 12'd1;
               pb = $urandom_range(0, 1) ? 12'd4095 : 12'd1;
            end else if (r < 95) begin
               pa = 12'($urandom_range(0, 4095));
               pb = 12'($urandom_range(0, 4095));
               if ($urandom_range(0, 1)) pa = 12'd0;
               else pb = 12'd0;
            end else begin
               pa = 12'($urandom_range(0, 4095));
               pb = 12'($urandom_range(0, 4095));
            end
            flags = ($urandom_range(0, 99) < 10) ? 3'($urandom_range(1, 7)) : 3'b000;
         end
         run_left--;
         if ($urandom_range(0, 3) == 0 && pa > 4 && pa < 4091) begin
            jit = int'(pa) + $urandom_range(0, 8) - 4;
            pa = jit[11:0];
         end
         if (phase == 2 && i == 30) hold_off = 60;
         if (phase == 4 && i == 40) drain_cmds();
         send_tick(pa, pb, flags);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      hold_off = 0;
      ticks_sent = 0;
      setups_run = 0;
      set_traffic(0);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(12'd1500, 12'd1000, 12'd2000, 12'd50, 12'd25, 12'd2, 12'd0, 12'd0);
      send_tick(12'd1500, 12'd1500, 3'b000);
      send_tick(12'd2000, 12'd2000, 3'b000);
      send_tick(12'd2000, 12'd2000, 3'b000);
      send_tick(12'd1000, 12'd1000, 3'b000);
      send_tick(12'd1000, 12'd1000, 3'b000);
      send_tick(12'd0, 12'd1800, 3'b000);
      send_tick(12'd1800, 12'd0, 3'b000);
      send_tick(12'd2000, 12'd2000, 3'b001);
      send_tick(12'd2000, 12'd2000, 3'b010);
      send_tick(12'd2000, 12'd2000, 3'b100);
      send_tick(12'd4095, 12'd4095, 3'b000);
      send_tick(12'd1, 12'd1, 3'b000);
      send_tick(12'd4095, 12'd1, 3'b000);
      send_tick(12'd1450, 12'd1550, 3'b000);
      send_tick(12'd1449, 12'd1551, 3'b000);
      send_tick(12'd1024, 12'd1976, 3'b000);
      send_tick(12'd1025, 12'd1975, 3'b000);
      send_tick(12'd1700, 12'd1300, 3'b000);
      send_tick(12'd1300, 12'd1700, 3'b000);
      send_tick(12'd0, 12'd0, 3'b111);
      drain_cmds();

      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: configure(12'd1500, 12'd1000, 12'd2000, 12'd50, 12'd25, 12'd2, 12'd0, 12'd0);
            1: configure(12'd1500, 12'd1000, 12'd2000, 12'd50, 12'd25, 12'd40, 12'd1, 12'd0);
            2: configure(12'd1500, 12'd1000, 12'd2000, 12'd20, 12'd10, 12'd255, 12'd0, 12'd3);
            3: configure(12'd1500, 12'd1000, 12'd2000, 12'd0, 12'd0, 12'd0, 12'd1, 12'd1);
            4: configure(12'd2048, 12'd0, 12'd4095, 12'd255, 12'd255, 12'd100, 12'd1, 12'd2);
            5: configure(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd7, 12'd0, 12'd0);
            6: configure(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                         12'hFFF);
            7: configure(12'd1000, 12'd3000, 12'd500, 12'd30, 12'd60, 12'd16, 12'd1, 12'd1);
            default: configure(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                               12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
         endcase
         run_random(85, phase);
         drain_cmds();
      end

      repeat (10) @(posedge clock);
      $display("ran %0d update ticks over %0d register setups, %0d motor commands checked",
               ticks_sent, setups_run, cmd_board.checked);
      $display("covered faults, lost channels, zero pulses, mirroring, arcade mix and ramp limits");
      if (cmd_board.failures == 0 && cmd_board.pending_cmds.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d failures, %0d commands missing", cmd_board.failures,
                  cmd_board.pending_cmds.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ dual_motor_mix_ramp_unit.f @@
rtl/dmmr_pkg.sv
rtl/dmmr_clamp.sv
rtl/dmmr_ramp_lane.sv
rtl/dual_motor_mix_ramp_unit.sv
tb/tb.sv
